FILE: sv/gmo_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the arctangent table of the gradient block
// no dependencies
package gmo_pkg;

  // default geometry and angle resolution
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int ACOS_STEPS_DEF = 10000;

  // channel limit of the datapath (store holds three bytes per pixel)
  localparam int MAX_CHANNELS = 3;
  localparam int CH_LIMIT     = (MAX_CHANNELS < 3) ? MAX_CHANNELS : 3;

  // field widths
  localparam int SAMPLE_W   = 8;
  localparam int PIX_W      = 24;
  localparam int POS_W      = 10;
  localparam int MAG_W      = 16;
  localparam int ANG_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // job queue depth
  localparam int QUEUE_DEPTH = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_CIRCLE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIENT_ENABLE = 3'd4;

  // angle constants, pi in q.16 and q3.13, and the cap just below pi
  localparam int Q16_PI  = 205887;
  localparam int Q13_PI  = 25736;
  localparam int Q13_CAP = 25735;

  // configuration register set
  typedef struct packed {
    logic [10:0] image_height;
    logic [10:0] image_width;
    logic [1:0]  channel_count;
    logic        full_circle;
    logic        orient_enable;
  } cfg_t;

  // one gradient job: two x operands, two y operands, border flags, position and end markers
  typedef struct packed {
    logic [PIX_W-1:0] xa;
    logic [PIX_W-1:0] xb;
    logic [PIX_W-1:0] ya;
    logic [PIX_W-1:0] yb;
    logic             xs;
    logic             ys;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             done;
    logic             last;
  } job_t;

  // atan(2^-i) in q.16
  function automatic logic [15:0] atan_q16(input logic [3:0] i);
    logic [15:0] v;
    case (i)
      4'd0:    v = 16'd51472;
      4'd1:    v = 16'd30386;
      4'd2:    v = 16'd16055;
      4'd3:    v = 16'd8150;
      4'd4:    v = 16'd4091;
      4'd5:    v = 16'd2047;
      4'd6:    v = 16'd1024;
      4'd7:    v = 16'd512;
      4'd8:    v = 16'd256;
      4'd9:    v = 16'd128;
      4'd10:   v = 16'd64;
      4'd11:   v = 16'd32;
      4'd12:   v = 16'd16;
      4'd13:   v = 16'd8;
      4'd14:   v = 16'd4;
      default: v = 16'd2;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/gmo_pix_if.sv
`timescale 1ns / 1ps
// pixel input channel: valid, ready and three channel samples
// depends on gmo_pkg
interface gmo_pix_if;
  logic                         valid;
  logic                         ready;
  logic [gmo_pkg::SAMPLE_W-1:0] chan0_sample;
  logic [gmo_pkg::SAMPLE_W-1:0] chan1_sample;
  logic [gmo_pkg::SAMPLE_W-1:0] chan2_sample;

  modport source (output valid, chan0_sample, chan1_sample, chan2_sample, input ready);
  modport sink (input valid, chan0_sample, chan1_sample, chan2_sample, output ready);
endinterface

FILE: sv/gmo_res_if.sv
`timescale 1ns / 1ps
// result channel: valid, ready, magnitude, angle, position and markers
// depends on gmo_pkg
interface gmo_res_if;
  logic                      valid;
  logic                      ready;
  logic [gmo_pkg::MAG_W-1:0] grad_magnitude;
  logic [gmo_pkg::ANG_W-1:0] grad_angle;
  logic [gmo_pkg::POS_W-1:0] pixel_row;
  logic [gmo_pkg::POS_W-1:0] pixel_col;
  logic                      last_of_run;
  logic                      image_done;

  modport source (output valid, grad_magnitude, grad_angle, pixel_row, pixel_col,
                  last_of_run, image_done, input ready);
  modport sink (input valid, grad_magnitude, grad_angle, pixel_row, pixel_col,
                last_of_run, image_done, output ready);
endinterface

FILE: sv/gmo_cfg_if.sv
`timescale 1ns / 1ps
// configuration write channel: valid, ready, register index and data
// depends on gmo_pkg
interface gmo_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [gmo_pkg::CFG_IDX_W-1:0]  index;
  logic [gmo_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/gmo_ram.sv
`timescale 1ns / 1ps
// generic simple dual port ram, one write and one registered read port
// no dependencies
module gmo_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/gmo_queue.sv
`timescale 1ns / 1ps
// short job queue between the front and the back
// depends on gmo_pkg
module gmo_queue #(
  parameter int DEPTH = gmo_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  gmo_pkg::job_t din,
  output logic          full,
  input  logic          pop,
  output gmo_pkg::job_t dout,
  output logic          empty
);
  import gmo_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  job_t            slots [DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [CNTW-1:0] count;

  assign full  = count == CNTW'(DEPTH);
  assign empty = count == '0;
  assign dout  = slots[rptr];

  // payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= din;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CNTW'(1);
      end else if (pop && !push) begin
        count <= count - CNTW'(1);
      end
    end
  end

endmodule

FILE: sv/gmo_front.sv
`timescale 1ns / 1ps
// front: accepts pixels, tracks position, gathers neighbor pixels from the
// column store and queues gradient jobs; depends on gmo_pkg, gmo_ram, gmo_pix_if
module gmo_front #(
  parameter int MAX_HEIGHT = gmo_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_WIDTH  = gmo_pkg::MAX_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  gmo_pkg::cfg_t cfg,
  input  logic          restart,
  gmo_pix_if.sink       pix,
  output gmo_pkg::job_t job,
  output logic          job_push,
  input  logic          job_full
);
  import gmo_pkg::*;

  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int CLW   = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int DEPTH = 2 * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  // job kinds per pixel
  localparam logic [1:0] JOB_BODY   = 2'd0;
  localparam logic [1:0] JOB_EDGE   = 2'd1;
  localparam logic [1:0] JOB_CORNER = 2'd2;

  // operand slots: 0 x low, 1 x high, 2 y low, 3 y high
  typedef struct packed {
    logic [3:0]         is_cur;
    logic [3:0][AW-1:0] addr;
    logic               xs;
    logic               ys;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic               done;
    logic               last;
  } desc_t;

  typedef enum logic [2:0] {F_IDLE, F_SEL, F_READ, F_PUSH, F_WRITE} fstate_t;

  fstate_t          state;
  logic [RW-1:0]    r;
  logic [CLW-1:0]   c;
  logic [RW-1:0]    rr;
  logic [CLW-1:0]   cc;
  logic [PIX_W-1:0] cur;
  logic [1:0]       jk;
  desc_t            dreg;
  desc_t            dsel;
  logic [2:0]       cnt;
  logic [PIX_W-1:0] opnd [4];

  logic [HW-1:0]  hu;
  logic [WW-1:0]  wu;
  logic [RW-1:0]  h_last;
  logic [2:0]     jp;
  logic           at_last_col;
  logic           wrap;
  logic [HW-1:0]  rn;
  logic [WW-1:0]  cn;
  logic [1:0]     opi;
  logic [PIX_W-1:0] rdata;

  function automatic logic [AW-1:0] slot_addr(input logic slot, input logic [RW-1:0] row);
    return slot ? AW'(MAX_HEIGHT) + AW'(row) : AW'(row);
  endfunction

  // clamped geometry
  always_comb begin
    if (cfg.image_height < 11'd2) begin
      hu = HW'(2);
    end else if (cfg.image_height > MAX_HEIGHT) begin
      hu = HW'(MAX_HEIGHT);
    end else begin
      hu = HW'(cfg.image_height);
    end
    if (cfg.image_width < 11'd2) begin
      wu = WW'(2);
    end else if (cfg.image_width > MAX_WIDTH) begin
      wu = WW'(MAX_WIDTH);
    end else begin
      wu = WW'(cfg.image_width);
    end
  end

  assign h_last      = RW'(hu - HW'(1));
  assign at_last_col = cc == CLW'(wu - WW'(1));
  assign wrap        = (HW'(r) >= hu) || (WW'(c) >= wu);
  assign jp[0]       = cc != '0;
  assign jp[1]       = at_last_col && (rr != '0);
  assign jp[2]       = at_last_col && (rr == h_last);
  assign rn          = HW'(rr) + HW'(1);
  assign cn          = WW'(cc) + WW'(1);
  assign opi         = 2'(cnt - 3'd1);

  // operand addresses of the selected job
  always_comb begin
    dsel = '0;
    case (jk)
      JOB_BODY: begin
        dsel.addr[0]   = slot_addr((cc == CLW'(1)) ? ~cc[0] : cc[0], rr);
        dsel.is_cur[1] = 1'b1;
        dsel.xs        = cc == CLW'(1);
        if (rr == '0) begin
          dsel.addr[2] = slot_addr(~cc[0], rr);
          dsel.addr[3] = slot_addr(~cc[0], RW'(1));
          dsel.ys      = 1'b1;
        end else if (rr == h_last) begin
          dsel.addr[2] = slot_addr(~cc[0], h_last - RW'(1));
          dsel.addr[3] = slot_addr(~cc[0], rr);
          dsel.ys      = 1'b1;
        end else begin
          dsel.addr[2] = slot_addr(~cc[0], rr - RW'(1));
          dsel.addr[3] = slot_addr(~cc[0], rr + RW'(1));
          dsel.ys      = 1'b0;
        end
        dsel.row  = POS_W'(rr);
        dsel.col  = POS_W'(cc - CLW'(1));
        dsel.last = !(jp[1] || jp[2]);
      end
      JOB_EDGE: begin
        // last column, row above the current one
        dsel.is_cur[3] = 1'b1;
        dsel.xs        = 1'b1;
        if (rr == RW'(1)) begin
          dsel.addr[0] = slot_addr(~cc[0], '0);
          dsel.addr[1] = slot_addr(cc[0], '0);
          dsel.addr[2] = slot_addr(cc[0], '0);
          dsel.ys      = 1'b1;
          dsel.row     = '0;
        end else begin
          dsel.addr[0] = slot_addr(~cc[0], rr - RW'(1));
          dsel.addr[1] = slot_addr(cc[0], rr - RW'(1));
          dsel.addr[2] = slot_addr(cc[0], rr - RW'(2));
          dsel.ys      = 1'b0;
          dsel.row     = POS_W'(rr - RW'(1));
        end
        dsel.col  = POS_W'(cc);
        dsel.last = !jp[2];
      end
      JOB_CORNER: begin
        // final pixel of the image
        dsel.addr[0]   = slot_addr(~cc[0], h_last);
        dsel.is_cur[1] = 1'b1;
        dsel.addr[2]   = slot_addr(cc[0], h_last - RW'(1));
        dsel.is_cur[3] = 1'b1;
        dsel.xs        = 1'b1;
        dsel.ys        = 1'b1;
        dsel.row       = POS_W'(h_last);
        dsel.col       = POS_W'(cc);
        dsel.done      = 1'b1;
        dsel.last      = 1'b1;
      end
      default: dsel = '0;
    endcase
  end

  // column store
  gmo_ram #(
    .WIDTH(PIX_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (state == F_WRITE),
    .waddr(slot_addr(cc[0], rr)),
    .wdata(cur),
    .re   ((state == F_READ) && (cnt != 3'd4)),
    .raddr(dreg.addr[cnt[1:0]]),
    .rdata(rdata)
  );

  // job payload toward the queue
  always_comb begin
    job.xa   = opnd[0];
    job.xb   = opnd[1];
    job.ya   = opnd[2];
    job.yb   = opnd[3];
    job.xs   = dreg.xs;
    job.ys   = dreg.ys;
    job.row  = dreg.row;
    job.col  = dreg.col;
    job.done = dreg.done;
    job.last = dreg.last;
  end

  assign job_push  = (state == F_PUSH) && !job_full;
  assign pix.ready = state == F_IDLE;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      r     <= '0;
      c     <= '0;
      jk    <= JOB_BODY;
      cnt   <= '0;
    end else begin
      if (restart) begin
        r <= '0;
        c <= '0;
      end
      case (state)
        F_IDLE: begin
          if (pix.valid) begin
            cur   <= {pix.chan2_sample, pix.chan1_sample, pix.chan0_sample};
            rr    <= wrap ? '0 : r;
            cc    <= wrap ? '0 : c;
            jk    <= JOB_BODY;
            state <= F_SEL;
          end
        end
        F_SEL: begin
          if (jp[jk]) begin
            dreg  <= dsel;
            cnt   <= '0;
            state <= F_READ;
          end else if (jk == JOB_CORNER) begin
            state <= F_WRITE;
          end else begin
            jk <= jk + 2'd1;
          end
        end
        F_READ: begin
          if (cnt != '0) begin
            opnd[opi] <= dreg.is_cur[opi] ? cur : rdata;
          end
          if (cnt == 3'd4) begin
            state <= F_PUSH;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        F_PUSH: begin
          if (!job_full) begin
            if (jk == JOB_CORNER) begin
              state <= F_WRITE;
            end else begin
              jk    <= jk + 2'd1;
              state <= F_SEL;
            end
          end
        end
        F_WRITE: begin
          // advance position, row first
          if (rn >= hu) begin
            r <= '0;
            c <= (cn >= wu) ? '0 : CLW'(cn);
          end else begin
            r <= RW'(rn);
            c <= cc;
          end
          state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/gmo_back.sv
`timescale 1ns / 1ps
// back: per job picks the strongest channel, then magnitude by square root and
// orientation by division, square root and cordic; depends on gmo_pkg, gmo_res_if
module gmo_back #(
  parameter int ACOS_STEPS = gmo_pkg::ACOS_STEPS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  gmo_pkg::cfg_t cfg,
  input  gmo_pkg::job_t job,
  input  logic          job_empty,
  output logic          job_pop,
  gmo_res_if.source     res
);
  import gmo_pkg::*;

  localparam int NW    = $clog2(ACOS_STEPS + 1);
  localparam int AX2W  = 18;
  localparam int SW    = 20;
  localparam int PRODW = 2 * NW + AX2W;
  localparam int SQW   = (PRODW > 32) ? PRODW : 32;
  localparam int SCW   = $clog2(SQW + 1);
  localparam int CW    = NW + 12;
  localparam int ZW    = 20;
  localparam logic [2*NW-1:0] N2     = (2 * NW)'(ACOS_STEPS * ACOS_STEPS);
  localparam logic [NW-1:0]   NQ     = NW'(ACOS_STEPS);
  localparam logic [SQW-1:0]  SQ_TOP = SQW'(1) << (SQW - 2);

  typedef enum logic [3:0] {
    B_IDLE, B_CHAN, B_SQST, B_SQRT, B_SQEND, B_AXSQ, B_MUL, B_DIV, B_QSQ,
    B_CORD, B_FIN, B_OUT
  } bstate_t;

  typedef enum logic [1:0] {PH_MAG, PH_Q, PH_Y} phase_t;

  bstate_t            state;
  phase_t             ph;
  job_t               jb;
  logic [1:0]         ch;
  logic [SW-1:0]      bs;
  logic signed [9:0]  bgx;
  logic signed [9:0]  bgy;
  logic [MAG_W-1:0]   mag;
  logic [AX2W-1:0]    ax2;
  logic [PRODW-1:0]   dvd;
  logic [SW:0]        drem;
  logic [SQW-1:0]     sv;
  logic [SQW-1:0]     sr;
  logic [SQW-1:0]     sb;
  logic [SCW-1:0]     scnt;
  logic [NW-1:0]      q;
  logic [2*NW-1:0]    qq;
  logic signed [CW-1:0] cx;
  logic signed [CW-1:0] cy;
  logic signed [ZW-1:0] cz;
  logic [3:0]         ci;

  logic [MAG_W-1:0] out_mag;
  logic [ANG_W-1:0] out_ang;
  logic [POS_W-1:0] out_row;
  logic [POS_W-1:0] out_col;
  logic             out_last;
  logic             out_done;

  logic [1:0]         nch;
  logic [1:0]         lastch;
  logic [7:0]         bxa, bxb, bya, byb;
  logic signed [8:0]  dx9, dy9;
  logic signed [9:0]  gx, gy;
  logic signed [19:0] gx2, gy2;
  logic [SW-1:0]      s_ch;
  logic [SQW-1:0]     rb;
  logic               sq_ge;
  logic [SQW-1:0]     mround;
  logic [SW:0]        dt;
  logic               dge;
  logic [8:0]         ax;
  logic signed [CW-1:0] dxs, dys;
  logic signed [ZW-1:0] at;
  logic signed [ZW-1:0] t0, t1, t2, t3;
  logic               neg;
  logic [ANG_W-1:0]   ang;

  // channels in use
  always_comb begin
    if (cfg.channel_count == 2'd0) begin
      nch = 2'd1;
    end else if (cfg.channel_count > 2'(CH_LIMIT)) begin
      nch = 2'(CH_LIMIT);
    end else begin
      nch = cfg.channel_count;
    end
  end
  assign lastch = nch - 2'd1;

  // gradient of one channel
  assign bxa = jb.xa[{ch, 3'b000} +: 8];
  assign bxb = jb.xb[{ch, 3'b000} +: 8];
  assign bya = jb.ya[{ch, 3'b000} +: 8];
  assign byb = jb.yb[{ch, 3'b000} +: 8];
  assign dx9 = $signed({1'b0, bxb}) - $signed({1'b0, bxa});
  assign dy9 = $signed({1'b0, byb}) - $signed({1'b0, bya});
  assign gx  = jb.xs ? {dx9, 1'b0} : {dx9[8], dx9};
  assign gy  = jb.ys ? {dy9, 1'b0} : {dy9[8], dy9};
  assign gx2 = gx * gx;
  assign gy2 = gy * gy;
  assign s_ch = gx2[SW-1:0] + gy2[SW-1:0];

  // square root digit step
  assign rb     = sr + sb;
  assign sq_ge  = sv >= rb;
  assign mround = sr + SQW'(sv > sr);

  // restoring divide step
  assign dt  = {drem[SW-1:0], dvd[PRODW-1]};
  assign dge = dt >= {1'b0, bs};

  assign ax = bgx[9] ? 9'(-bgx) : 9'(bgx);

  // cordic step terms
  assign dxs = cy >>> ci;
  assign dys = cx >>> ci;
  assign at  = $signed({{(ZW - 16){1'b0}}, atan_q16(ci)});

  // angle from the cordic result
  always_comb begin
    neg = (q != '0) && (bgx[9] != bgy[9]);
    t0  = cz[ZW-1] ? '0 : cz;
    t1  = neg ? ZW'(Q16_PI) - t0 : t0;
    t2  = t1[ZW-1] ? '0 : t1;
    t3  = (t2 + ZW'(4)) >>> 3;
    if (t3 > ZW'(Q13_CAP)) begin
      t3 = ZW'(Q13_CAP);
    end
    if (cfg.full_circle && bgy[9]) begin
      t3 = t3 + ZW'(Q13_PI);
    end
    ang = cfg.orient_enable ? ANG_W'(t3) : '0;
  end

  assign job_pop            = (state == B_IDLE) && !job_empty;
  assign res.valid          = state == B_OUT;
  assign res.grad_magnitude = out_mag;
  assign res.grad_angle     = out_ang;
  assign res.pixel_row      = out_row;
  assign res.pixel_col      = out_col;
  assign res.last_of_run    = out_last;
  assign res.image_done     = out_done;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      ph    <= PH_MAG;
      ch    <= '0;
      scnt  <= '0;
      ci    <= '0;
    end else begin
      case (state)
        B_IDLE: begin
          if (!job_empty) begin
            jb    <= job;
            ch    <= '0;
            state <= B_CHAN;
          end
        end
        B_CHAN: begin
          // strongest channel, ties keep the lower one
          if (ch == '0 || s_ch > bs) begin
            bs  <= s_ch;
            bgx <= gx;
            bgy <= gy;
          end
          if (ch == lastch) begin
            ph    <= PH_MAG;
            state <= B_SQST;
          end else begin
            ch <= ch + 2'd1;
          end
        end
        B_SQST: begin
          case (ph)
            PH_MAG:  sv <= SQW'({bs, 12'b0});
            PH_Q:    sv <= SQW'(dvd);
            default: sv <= SQW'({N2 - qq, 16'b0});
          endcase
          sr    <= '0;
          sb    <= SQ_TOP;
          scnt  <= '0;
          state <= B_SQRT;
        end
        B_SQRT: begin
          if (sq_ge) begin
            sv <= sv - rb;
            sr <= (sr >> 1) + sb;
          end else begin
            sr <= sr >> 1;
          end
          sb <= sb >> 2;
          if (scnt == SCW'(SQW / 2 - 1)) begin
            state <= B_SQEND;
          end else begin
            scnt <= scnt + SCW'(1);
          end
        end
        B_SQEND: begin
          case (ph)
            PH_MAG: begin
              // round to nearest, saturate
              mag <= (mround > SQW'(16'hFFFF)) ? 16'hFFFF : mround[MAG_W-1:0];
              if (!cfg.orient_enable) begin
                state <= B_FIN;
              end else if (bs == '0) begin
                q     <= '0;
                state <= B_QSQ;
              end else begin
                state <= B_AXSQ;
              end
            end
            PH_Q: begin
              q     <= (sr > SQW'(NQ)) ? NQ : sr[NW-1:0];
              state <= B_QSQ;
            end
            default: begin
              cx    <= $signed({{(CW - NW - 8){1'b0}}, q, 8'b0});
              cy    <= $signed(sr[CW-1:0]);
              cz    <= '0;
              ci    <= '0;
              state <= B_CORD;
            end
          endcase
        end
        B_AXSQ: begin
          ax2   <= ax * ax;
          state <= B_MUL;
        end
        B_MUL: begin
          dvd   <= N2 * ax2;
          drem  <= '0;
          scnt  <= '0;
          state <= B_DIV;
        end
        B_DIV: begin
          drem <= dge ? dt - {1'b0, bs} : dt;
          dvd  <= {dvd[PRODW-2:0], dge};
          if (scnt == SCW'(PRODW - 1)) begin
            ph    <= PH_Q;
            state <= B_SQST;
          end else begin
            scnt <= scnt + SCW'(1);
          end
        end
        B_QSQ: begin
          qq    <= q * q;
          ph    <= PH_Y;
          state <= B_SQST;
        end
        B_CORD: begin
          if (!cy[CW-1]) begin
            cx <= cx + dxs;
            cy <= cy - dys;
            cz <= cz + at;
          end else begin
            cx <= cx - dxs;
            cy <= cy + dys;
            cz <= cz - at;
          end
          ci <= ci + 4'd1;
          if (ci == 4'd15) begin
            state <= B_FIN;
          end
        end
        B_FIN: begin
          out_mag  <= mag;
          out_ang  <= ang;
          out_row  <= jb.row;
          out_col  <= jb.col;
          out_last <= jb.last;
          out_done <= jb.done;
          state    <= B_OUT;
        end
        B_OUT: begin
          if (res.ready) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/gradient_magnitude_orientation.sv
`timescale 1ns / 1ps
// Gradient magnitude and orientation over a pixel stream, column by column.
// Pixels enter on pix (valid/ready, three 8-bit samples), rows 0..H-1 of
// column 0, then column 1 and so on. Results leave on res: magnitude Q10.6,
// angle Q3.13, row, column, last_of_run and image_done. Registers are written
// on cfg (index 0 height, 1 width, 2 channel count, 3 full circle, 4 angle
// enable); the user must write them only while the block is idle, which the
// block itself does not enforce. A height or width write restarts the image.
// Column 0 yields no result, each later pixel one, the last column up to three.
// The front takes one pixel, reads its neighbors from the column store one
// address a cycle and stores the pixel. The back works one result at a time
// through a shared digit-serial square root, a bit-serial divider and a
// 16-step cordic. A two-entry job queue lets the front keep taking pixels
// while the back or a stalled receiver holds a result. A result waits in the
// output register until taken. Reset restores register defaults and position
// 0; the column store needs no clearing.
// depends on gmo_pkg, the channel interfaces, gmo_front, gmo_queue, gmo_back
module gradient_magnitude_orientation #(
  parameter int MAX_HEIGHT = gmo_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_WIDTH  = gmo_pkg::MAX_WIDTH_DEF,
  parameter int ACOS_STEPS = gmo_pkg::ACOS_STEPS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  gmo_pix_if.sink   pix,
  gmo_res_if.source res,
  gmo_cfg_if.sink   cfg
);
  import gmo_pkg::*;

  cfg_t cregs;
  logic restart;
  job_t q_in;
  job_t q_out;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;

  assign cfg.ready = 1'b1;
  assign restart   = cfg.valid &&
                     (cfg.index == REG_IMAGE_HEIGHT || cfg.index == REG_IMAGE_WIDTH);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cregs.image_height  <= 11'd64;
      cregs.image_width   <= 11'd64;
      cregs.channel_count <= 2'd1;
      cregs.full_circle   <= 1'b0;
      cregs.orient_enable <= 1'b1;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_IMAGE_HEIGHT:  cregs.image_height  <= cfg.data;
        REG_IMAGE_WIDTH:   cregs.image_width   <= cfg.data;
        REG_CHANNEL_COUNT: cregs.channel_count <= cfg.data[1:0];
        REG_FULL_CIRCLE:   cregs.full_circle   <= cfg.data[0];
        REG_ORIENT_ENABLE: cregs.orient_enable <= cfg.data[0];
        default: ;
      endcase
    end
  end

  gmo_front #(
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cregs),
    .restart (restart),
    .pix     (pix),
    .job     (q_in),
    .job_push(q_push),
    .job_full(q_full)
  );

  gmo_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (q_in),
    .full (q_full),
    .pop  (q_pop),
    .dout (q_out),
    .empty(q_empty)
  );

  gmo_back #(
    .ACOS_STEPS(ACOS_STEPS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cregs),
    .job      (q_out),
    .job_empty(q_empty),
    .job_pop  (q_pop),
    .res      (res)
  );

endmodule

FILE: dv/gmo_checker.sv
`timescale 1ns / 1ps
// checker for the gradient block: watches the pixel, result and register channels,
// predicts each result from its own image model and compares field by field
// depends on gmo_pkg and the three channel interfaces
module gmo_checker (
  input  logic clk,
  input  logic rst,
  gmo_pix_if   pix,
  gmo_res_if   res,
  gmo_cfg_if   cfg,
  output int   fails,
  output int   pending
);
  import gmo_pkg::*;

  localparam int ROWS_MAX  = 1024;
  localparam int COLS_MAX  = 1024;
  localparam longint STEPS = 10000;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [ANG_W-1:0] ang;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
    logic             done;
  } grad_res_t;

  // atan(2^-i) in q.16 for the angle rotation
  localparam longint ATAN_STEP [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                        256, 128, 64, 32, 16, 8, 4, 2};

  logic [PIX_W-1:0] col_store [2*ROWS_MAX];
  int unsigned      cur_row, cur_col;
  cfg_t             regs;
  grad_res_t        expected_q [$];

  assign pending = expected_q.size();

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // acos(m/steps) in q.16 by cordic vectoring
  function automatic longint acos_cordic(input longint m);
    longint x, y, z, dx, dy;
    z = 0;
    if (m > STEPS) m = STEPS;
    x = m <<< 8;
    y = longint'(int_sqrt(longint'((STEPS * STEPS - m * m) <<< 16)));
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + ATAN_STEP[i];
      end else begin
        x = x - dx; y = y + dy; z = z - ATAN_STEP[i];
      end
    end
    return z;
  endfunction

  function automatic int unsigned clamp_to(input int unsigned v, lo, hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic [PIX_W-1:0] fetch(input int unsigned slot, row);
    return col_store[slot * ROWS_MAX + row];
  endfunction

  // pick the strongest channel gradient and form magnitude and angle
  function automatic grad_res_t gradient_of(input logic [PIX_W-1:0] xa, xb, input bit xs,
                                            input logic [PIX_W-1:0] ya, yb, input bit ys,
                                            input int unsigned row, col, input bit done);
    grad_res_t o;
    longint gx, gy, s, bgx, bgy, bs, ax, q, t;
    longint unsigned s2, mag;
    int unsigned nch;
    bit neg;
    bgx = 0; bgy = 0; bs = 0; q = 0; t = 0;
    nch = clamp_to(regs.channel_count, 1, CH_LIMIT);
    for (int ch = 0; ch < nch; ch++) begin
      gx = (longint'(xb[8*ch +: 8]) - longint'(xa[8*ch +: 8])) * (xs ? 2 : 1);
      gy = (longint'(yb[8*ch +: 8]) - longint'(ya[8*ch +: 8])) * (ys ? 2 : 1);
      s = gx * gx + gy * gy;
      if (ch == 0 || s > bs) begin
        bs = s; bgx = gx; bgy = gy;
      end
    end
    s2 = longint'(bs) * 4096;
    mag = int_sqrt(s2);
    if (s2 - mag * mag > mag) mag++;
    if (mag > 65535) mag = 65535;
    o = '0;
    o.mag = mag[15:0];
    if (regs.orient_enable) begin
      ax = bgx < 0 ? -bgx : bgx;
      if (bs > 0) q = longint'(int_sqrt((STEPS * STEPS * ax * ax) / bs));
      if (q > STEPS) q = STEPS;
      neg = q > 0 && ((bgx < 0) != (bgy < 0));
      t = acos_cordic(q);
      if (t < 0) t = 0;
      if (neg) t = Q16_PI - t;
      if (t < 0) t = 0;
      t = (t + 4) >>> 3;
      if (t > Q13_CAP) t = Q13_CAP;
      if (regs.full_circle && bgy < 0) t = t + Q13_PI;
      o.ang = t[15:0];
    end
    o.row = row[9:0];
    o.col = col[9:0];
    o.done = done;
    return o;
  endfunction

  // one accepted pixel: queue the results it completes and store it
  task automatic predict_pixel(input logic [PIX_W-1:0] cur);
    int unsigned h, w, r, c, cs, ps, ls, ps2;
    logic [PIX_W-1:0] self, xa;
    grad_res_t outs [$];
    h = clamp_to(regs.image_height, 2, ROWS_MAX);
    w = clamp_to(regs.image_width, 2, COLS_MAX);
    r = cur_row;
    c = cur_col;
    if (r >= h || c >= w) begin
      r = 0; c = 0;
    end
    if (c >= 1) begin
      cs = (c - 1) & 1;
      ps = c & 1;
      self = fetch(cs, r);
      xa = (c == 1) ? self : fetch(ps, r);
      if (r == 0)
        outs.push_back(gradient_of(xa, cur, c == 1, self, fetch(cs, 1), 1, r, c - 1, 0));
      else if (r == h - 1)
        outs.push_back(gradient_of(xa, cur, c == 1, fetch(cs, h - 2), self, 1, r, c - 1, 0));
      else
        outs.push_back(gradient_of(xa, cur, c == 1, fetch(cs, r - 1), fetch(cs, r + 1), 0,
                                   r, c - 1, 0));
    end
    // last column trails by one row and closes the image
    if (c == w - 1) begin
      ls = (w - 1) & 1;
      ps2 = (w - 2) & 1;
      if (r >= 1) begin
        self = fetch(ls, r - 1);
        if (r == 1)
          outs.push_back(gradient_of(fetch(ps2, 0), self, 1, self, cur, 1, 0, w - 1, 0));
        else
          outs.push_back(gradient_of(fetch(ps2, r - 1), self, 1, fetch(ls, r - 2), cur, 0,
                                     r - 1, w - 1, 0));
      end
      if (r == h - 1)
        outs.push_back(gradient_of(fetch(ps2, h - 1), cur, 1, fetch(ls, h - 2), cur, 1,
                                   h - 1, w - 1, 1));
    end
    col_store[(c & 1) * ROWS_MAX + r] = cur;
    r++;
    if (r >= h) begin
      r = 0;
      c++;
      if (c >= w) c = 0;
    end
    cur_row = r;
    cur_col = c;
    if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
    foreach (outs[i]) expected_q.push_back(outs[i]);
  endtask

  // compare one result transaction against the oldest expectation
  task automatic compare_result();
    grad_res_t e;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result mag=%0d ang=%0d row=%0d col=%0d", $time,
               res.grad_magnitude, res.grad_angle, res.pixel_row, res.pixel_col);
      fails++;
      return;
    end
    e = expected_q.pop_front();
    if (res.grad_magnitude !== e.mag) begin
      $display("%0t: magnitude expected %0d actual %0d", $time, e.mag, res.grad_magnitude);
      fails++;
    end
    if (res.grad_angle !== e.ang) begin
      $display("%0t: angle expected %0d actual %0d", $time, e.ang, res.grad_angle);
      fails++;
    end
    if (res.pixel_row !== e.row) begin
      $display("%0t: row expected %0d actual %0d", $time, e.row, res.pixel_row);
      fails++;
    end
    if (res.pixel_col !== e.col) begin
      $display("%0t: column expected %0d actual %0d", $time, e.col, res.pixel_col);
      fails++;
    end
    if (res.last_of_run !== e.last) begin
      $display("%0t: last_of_run expected %0d actual %0d", $time, e.last, res.last_of_run);
      fails++;
    end
    if (res.image_done !== e.done) begin
      $display("%0t: image_done expected %0d actual %0d", $time, e.done, res.image_done);
      fails++;
    end
  endtask

  // sample all three channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      cur_row = 0;
      cur_col = 0;
      regs = '{image_height: 11'd64, image_width: 11'd64, channel_count: 2'd1,
               full_circle: 1'b0, orient_enable: 1'b1};
      expected_q.delete();
      fails = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_IMAGE_HEIGHT: begin
            regs.image_height = cfg.data;
            cur_row = 0;
            cur_col = 0;
          end
          REG_IMAGE_WIDTH: begin
            regs.image_width = cfg.data;
            cur_row = 0;
            cur_col = 0;
          end
          REG_CHANNEL_COUNT: regs.channel_count = cfg.data[1:0];
          REG_FULL_CIRCLE:   regs.full_circle = cfg.data[0];
          REG_ORIENT_ENABLE: regs.orient_enable = cfg.data[0];
          default: ;
        endcase
      end
      if (pix.valid && pix.ready)
        predict_pixel({pix.chan2_sample, pix.chan1_sample, pix.chan0_sample});
      if (res.valid && res.ready) compare_result();
    end
  end
endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// top of the gradient block test: clock, reset, pixel and register stimulus,
// receiver stalls, watchdog and verdict; depends on gmo_pkg, the interfaces, gmo_checker
module testbench;
  import gmo_pkg::*;

  localparam int IDLE_LIMIT  = 20000;
  localparam int DRAIN_WAIT  = 400;
  localparam int HOLD_CYCLES = 600;
  localparam int ITEM_TARGET = 430;

  logic clk;
  logic rst;
  int   fails;
  int   pending;
  int   pixels_sent;
  int   idle_cycles;
  bit   hold_req;
  bit   no_gaps;

  gmo_pix_if pix ();
  gmo_res_if res ();
  gmo_cfg_if cfg ();

  gradient_magnitude_orientation dut (.clk(clk), .rst(rst), .pix(pix), .res(res), .cfg(cfg));

  gmo_checker u_checker (.clk(clk), .rst(rst), .pix(pix), .res(res), .cfg(cfg),
                         .fails(fails), .pending(pending));

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (no_gaps || p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [7:0] sample_value();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (pix.valid && pix.ready) || (res.valid && res.ready) ||
        (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random ready with gaps, and one long hold when asked
  initial begin
    res.ready = 1'b0;
    @(negedge clk iff !rst);
    forever begin
      if (hold_req) begin
        res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 0;
      end
      res.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      if (gap_len() > 0) begin
        res.ready <= 1'b0;
        repeat (gap_len() + 1) @(negedge clk);
      end
    end
  end

  // called at a falling edge, returns at a falling edge after acceptance and any random gap
  task automatic send_pixel(input logic [7:0] s0, s1, s2);
    int g;
    pix.valid <= 1'b1;
    pix.chan0_sample <= s0;
    pix.chan1_sample <= s1;
    pix.chan2_sample <= s2;
    do @(posedge clk); while (!pix.ready);
    @(negedge clk);
    pixels_sent++;
    g = gap_len();
    if (g > 0) begin
      pix.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
    @(negedge clk);
  endtask

  // stop offering, let every expected transaction arrive, then let the front settle
  task automatic drain();
    pix.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic set_regs(input int h, w, ch, fc, oe);
    drain();
    write_reg(REG_IMAGE_HEIGHT, 11'(h));
    write_reg(REG_IMAGE_WIDTH, 11'(w));
    write_reg(REG_CHANNEL_COUNT, 11'(ch));
    write_reg(REG_FULL_CIRCLE, 11'(fc));
    write_reg(REG_ORIENT_ENABLE, 11'(oe));
  endtask

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) send_pixel(sample_value(), sample_value(), sample_value());
  endtask

  initial begin
    int h, w, n, area;
    rst = 1'b1;
    pix.valid = 1'b0;
    pix.chan0_sample = '0;
    pix.chan1_sample = '0;
    pix.chan2_sample = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    pixels_sent = 0;
    hold_req = 0;
    no_gaps = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // smallest image, three channels, full circle; extremes then a flat image
    set_regs(2, 2, 3, 1, 1);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    repeat (4) send_pixel(8'd77, 8'd77, 8'd77);
    // channel ties and a negative y gradient on a 3x3 image
    set_regs(3, 3, 2, 0, 1);
    send_pixel(8'd10, 8'd10, 8'd0);
    send_pixel(8'd200, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd200, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd1);
    send_pixel(8'd0, 8'd0, 8'd254);
    send_pixel(8'd128, 8'd127, 8'd0);
    send_pixel(8'd1, 8'd2, 8'd3);
    send_pixel(8'd255, 8'd0, 8'd128);
    send_pixel(8'd0, 8'd255, 8'd64);
    // out-of-range registers clamp: height 0, width 1, no channels
    set_regs(0, 1, 0, 1, 0);
    send_random(4);
    // oversized geometry clamps to the maximum; a partial column, then a restart
    set_regs(2047, 2047, 3, 0, 1);
    send_random(5);
    // receiver holds off while pixels keep coming, so the block fills and stalls
    set_regs(4, 8, 3, 0, 1);
    hold_req = 1;
    send_random(32);

    // random images, mostly small and whole
    while (pixels_sent < ITEM_TARGET) begin
      h = ($urandom_range(0, 9) < 8) ? $urandom_range(2, 6) : $urandom_range(7, 40);
      w = $urandom_range(2, 6);
      if ($urandom_range(0, 19) == 0) h = 1024;
      set_regs(h, w, $urandom_range(0, 3), $urandom_range(0, 1),
               ($urandom_range(0, 3) != 0));
      area = h * w;
      if (area > 60 || $urandom_range(0, 9) == 0)
        n = $urandom_range(1, (area > 60) ? 30 : area);
      else
        n = area * $urandom_range(1, 2);
      no_gaps = ($urandom_range(0, 3) == 0);
      send_random(n);
      no_gaps = 0;
    end

    pix.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
